// ----- design/ews_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_pkg: shared types and constants of the wakeup scheduler
// Source codes, field widths and the link struct passed along the cell chain.
// ----------------------------------------------------------------------------
package ews_pkg;

  localparam int SRC_W  = 2;
  localparam int TIME_W = 32;
  localparam int NUM_SRC = 3;

  typedef logic [SRC_W-1:0]  src_t;
  typedef logic [TIME_W-1:0] time_t;

  // request codes and wake sources share one encoding
  localparam src_t OP_CLEAR_ALL = 2'd0;
  localparam src_t SRC_NONE     = 2'd0;
  localparam src_t SRC_DUTY     = 2'd1;
  localparam src_t SRC_MESSAGE  = 2'd2;
  localparam src_t SRC_SAMPLE   = 2'd3;

  // cell order along the chain is the tie-break priority
  localparam src_t CELL_SRC [NUM_SRC] = '{SRC_DUTY, SRC_MESSAGE, SRC_SAMPLE};

  // largest reload that still fits the 16-bit timer mode
  localparam time_t WIDE_RELOAD_MAX = 32'd65535;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic  armed;
    time_t due;
    src_t  src;
  } best_t;

endpackage

// ----- design/ews_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_if: request and result channels of the wakeup scheduler
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ews_req_if;
  logic              valid;
  logic              ready;
  ews_pkg::src_t     op;
  ews_pkg::time_t    duration;
  ews_pkg::time_t    now;

  modport source (output valid, output op, output duration, output now, input ready);
  modport sink   (input valid, input op, input duration, input now, output ready);
endinterface

interface ews_rsp_if;
  logic              valid;
  logic              ready;
  logic              timer_on;
  ews_pkg::time_t    reload;
  logic              wide_mode;
  ews_pkg::src_t     wake_source;

  modport source (output valid, output timer_on, output reload, output wide_mode,
                  output wake_source, input ready);
  modport sink   (input valid, input timer_on, input reload, input wide_mode,
                  input wake_source, output ready);
endinterface

// ----- design/earliest_of_three_wakeup_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_of_three_wakeup_scheduler: earliest-deadline wake timer setup
// Three deadline cells in a chain; each request updates the slots and picks
// the earliest armed deadline, which sets the wake timer reload and mode.
//
//   Channel   Dir  Payload                                  Transfer
//   in_req    in   op, duration, now                        valid & ready
//   out_rsp   out  timer_on, reload, wide_mode, wake_source valid & ready
//
// One request per cycle while the output register is free or draining; its
// result appears in the output register in the cycle after the request is
// taken. The single cell chain and the reload subtract feed it combinationally.
// A new request is taken whenever the output register is empty or is being
// drained in the same cycle. Reset clears all three deadlines (unarmed).
// ----------------------------------------------------------------------------
module earliest_of_three_wakeup_scheduler (
  input logic          clk,
  input logic          rst_n,
  ews_req_if.sink      in_req,
  ews_rsp_if.source    out_rsp
);
  import ews_pkg::*;

  logic  accept;
  time_t arm_val;
  best_t chain [NUM_SRC+1];
  best_t best;
  time_t span;
  time_t reload_nxt;

  logic  out_valid_r;
  logic  timer_on_r;
  time_t reload_r;
  logic  wide_mode_r;
  src_t  wake_source_r;

  // take a request when the output register is free or draining
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  // shared arm value: now plus duration, zero duration disarms
  assign arm_val = (in_req.duration != '0) ? (in_req.now + in_req.duration) : '0;

  // seed the chain with an empty candidate
  assign chain[0] = '{armed: 1'b0, due: '0, src: SRC_NONE};

  for (genvar i = 0; i < NUM_SRC; i++) begin : g_cell
    ews_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .cell_src (CELL_SRC[i]),
      .op       (in_req.op),
      .arm_val  (arm_val),
      .now      (in_req.now),
      .best_in  (chain[i]),
      .best_out (chain[i+1])
    );
  end

  assign best = chain[NUM_SRC];

  // reload is the distance raised to one, minus one
  assign span       = best.due - in_req.now;
  assign reload_nxt = (!best.armed || (span == '0)) ? '0 : (span - time_t'(1));

  // advance the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      timer_on_r    <= best.armed;
      reload_r      <= reload_nxt;
      wide_mode_r   <= (reload_nxt > WIDE_RELOAD_MAX);
      wake_source_r <= best.armed ? best.src : SRC_NONE;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.timer_on    = timer_on_r;
  assign out_rsp.reload      = reload_r;
  assign out_rsp.wide_mode   = wide_mode_r;
  assign out_rsp.wake_source = wake_source_r;

  // an idle timer reports no source and a zero reload
  a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !timer_on_r) |-> ((reload_r == '0) && !wide_mode_r))
    else $error("timer off with nonzero reload or wide mode");

  a_on_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (timer_on_r == (wake_source_r != SRC_NONE)))
    else $error("timer_on disagrees with wake_source");

  a_wide_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (wide_mode_r == (reload_r > WIDE_RELOAD_MAX)))
    else $error("wide_mode does not track reload");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.op == OP_CLEAR_ALL)) |=> (out_valid_r && !timer_on_r))
    else $error("clear-all request left a deadline armed");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid_r) && !$past(out_rsp.ready)) |-> (out_valid_r && $stable(reload_r)))
    else $error("stalled result changed");

endmodule

// ----- design/ews_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ews_cell: one deadline slot of the scheduler chain
// Holds one source's deadline, updates it per request, clamps overdue values
// and passes the earlier of its own deadline and the incoming best onward.
// ----------------------------------------------------------------------------
module ews_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  ews_pkg::src_t  cell_src,
  input  ews_pkg::src_t  op,
  input  ews_pkg::time_t arm_val,
  input  ews_pkg::time_t now,
  input  ews_pkg::best_t best_in,
  output ews_pkg::best_t best_out
);
  import ews_pkg::*;

  time_t dl_r, dl_nxt;
  time_t dl_upd;

  // apply the request to this slot, then pull an overdue deadline up to now
  always_comb begin
    if (op == OP_CLEAR_ALL) begin
      dl_upd = '0;
    end else if (op == cell_src) begin
      dl_upd = arm_val;
    end else begin
      dl_upd = dl_r;
    end
    if ((dl_upd != '0) && (dl_upd < now)) begin
      dl_nxt = now;
    end else begin
      dl_nxt = dl_upd;
    end
  end

  // take over the lead only when strictly earlier; ties stay upstream
  always_comb begin
    best_out = best_in;
    if ((dl_nxt != '0) && (!best_in.armed || (dl_nxt < best_in.due))) begin
      best_out.armed = 1'b1;
      best_out.due   = dl_nxt;
      best_out.src   = cell_src;
    end
  end

  // hold the deadline between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= '0;
    end else if (accept) begin
      dl_r <= dl_nxt;
    end
  end

endmodule
